// ===== design/wsfd_pkg.sv =====
`default_nettype none
package wsfd_pkg;

   localparam int LENGTH_BITS_DEFAULT = 31;
   localparam logic STRICT_RESET = 1'b1;

   localparam logic [3:0] OP_CONT   = 4'h0;
   localparam logic [3:0] OP_TEXT   = 4'h1;
   localparam logic [3:0] OP_BINARY = 4'h2;
   localparam logic [3:0] OP_CLOSE  = 4'h8;
   localparam logic [3:0] OP_PING   = 4'h9;
   localparam logic [3:0] OP_PONG   = 4'hA;

   localparam logic [6:0] LEN_EXT16     = 7'd126;
   localparam logic [6:0] CTRL_MAX_LEN  = 7'd125;
   localparam logic [3:0] EXT16_BYTES   = 4'd2;
   localparam logic [3:0] EXT64_BYTES   = 4'd8;
   localparam logic [3:0] MASK_BYTES    = 4'd4;
   localparam logic [3:0] REASON_BYTES  = 4'd2;

   typedef enum logic [2:0] {
      PH_HDR0  = 3'd0,
      PH_HDR1  = 3'd1,
      PH_EXT   = 3'd2,
      PH_EXT_M = 3'd3,
      PH_MASK  = 3'd4,
      PH_DATA  = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      ACT_NONE      = 3'd0,
      ACT_FRAGMENT  = 3'd1,
      ACT_COMPLETE  = 3'd2,
      ACT_PONG      = 3'd3,
      ACT_PONG_IGN  = 3'd4,
      ACT_CLOSE_OK  = 3'd5,
      ACT_CLOSE_ERR = 3'd6,
      ACT_TOO_BIG   = 3'd7
   } action_type;

   typedef struct packed {
      logic       payload_valid;
      logic [7:0] payload_byte;
      logic [3:0] message_type;
      logic       frame_end;
      action_type action;
   } rsp_type;

   function automatic logic close_reason_bad(input logic [15:0] r);
      logic bad;
      bad = (r < 16'd1000) || (r == 16'd1004) || (r == 16'd1005) || (r == 16'd1006) ||
            ((r >= 16'd1012) && (r < 16'd3000)) || (r >= 16'd5000);
      return bad;
   endfunction

endpackage
`default_nettype wire

// ===== design/websocket_frame_decoder.sv =====
// result: each result is registered in the result buffer before it appears on rsp_*
// throughput: one byte per cycle; all parsing is one combinational pass from the
//   state registers into a two-entry result buffer, req_tready drops only when it is full
// reset: synchronous active-high, parser waits for a first header byte, strict_checks = 1,
//   result buffer empty; no clearing pass
`default_nettype none
module websocket_frame_decoder #(
   parameter int LENGTH_BITS = wsfd_pkg::LENGTH_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [7:0] payload_byte, [10:8] action, rest zero
   output logic [4:0]       rsp_tuser,   // [0] payload_valid, [4:1] message_type
   output logic             rsp_tlast    // frame_end
);
   import wsfd_pkg::*;

   // parser state
   logic                   strict_ff;
   phase_type              phase_ff, phase_in;
   logic [7:0]             hfirst_ff, hfirst_in;
   logic [6:0]             short_ff, short_in;
   logic [3:0]             hcount_ff, hcount_in;
   logic [31:0]            key_ff, key_in;
   logic [1:0]             mphase_ff, mphase_in;
   logic [LENGTH_BITS-1:0] left_ff, left_in;
   logic [1:0]             msgop_ff, msgop_in;
   logic [15:0]            reason_ff, reason_in;
   logic                   closed_ff, closed_in;

   // result buffer
   rsp_type                buf_ff [2];
   logic                   head_ff;
   logic [1:0]             count_ff;

   logic                   accept, pop, push;
   rsp_type                res;

   logic [7:0]             b, d, kb;
   logic                   do_known, known_masked, do_fail, do_finish, fin_valid;
   action_type             fail_code, fin_act;
   logic [3:0]             op;

   assign accept = req_tvalid && req_tready;
   assign pop    = rsp_tvalid && rsp_tready;
   assign b      = req_tdata;

   always_comb begin
      phase_in     = phase_ff;
      hfirst_in    = hfirst_ff;
      short_in     = short_ff;
      hcount_in    = hcount_ff;
      key_in       = key_ff;
      mphase_in    = mphase_ff;
      left_in      = left_ff;
      msgop_in     = msgop_ff;
      reason_in    = reason_ff;
      closed_in    = closed_ff;
      do_known     = 1'b0;
      known_masked = 1'b0;
      do_fail      = 1'b0;
      do_finish    = 1'b0;
      fin_valid    = 1'b0;
      fail_code    = ACT_CLOSE_ERR;
      fin_act      = ACT_NONE;
      push         = 1'b0;
      res          = '0;
      d            = 8'd0;
      kb           = 8'd0;
      op           = hfirst_ff[3:0];

      if (accept && !closed_ff) begin
         unique case (phase_ff)
            PH_HDR1: begin
               short_in  = b[6:0];
               hcount_in = 4'd0;
               if (b[6:0] < LEN_EXT16) begin
                  left_in      = LENGTH_BITS'(b[6:0]);
                  do_known     = 1'b1;
                  known_masked = b[7];
               end else begin
                  phase_in = b[7] ? PH_EXT_M : PH_EXT;
               end
            end
            PH_EXT, PH_EXT_M: begin
               if (|left_ff[LENGTH_BITS-1:LENGTH_BITS-8]) begin
                  do_fail   = 1'b1;
                  fail_code = ACT_TOO_BIG;
               end else begin
                  left_in   = {left_ff[LENGTH_BITS-9:0], b};
                  hcount_in = hcount_ff + 4'd1;
                  if (hcount_in == ((short_ff == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES)) begin
                     do_known     = 1'b1;
                     known_masked = (phase_ff == PH_EXT_M);
                  end
               end
            end
            PH_MASK: begin
               key_in    = {key_ff[23:0], b};
               hcount_in = hcount_ff + 4'd1;
               if (hcount_in == MASK_BYTES) begin
                  hcount_in = 4'd0;
                  if (left_ff == '0) begin
                     do_finish = 1'b1;
                  end else begin
                     phase_in = PH_DATA;
                  end
               end
            end
            PH_DATA: begin
               case (mphase_ff)
                  2'd0:    kb = key_ff[31:24];
                  2'd1:    kb = key_ff[23:16];
                  2'd2:    kb = key_ff[15:8];
                  default: kb = key_ff[7:0];
               endcase
               d         = b ^ kb;
               mphase_in = mphase_ff + 2'd1;
               if (hcount_ff < REASON_BYTES) begin
                  reason_in = {reason_ff[7:0], d};
                  hcount_in = hcount_ff + 4'd1;
               end
               left_in = left_ff - LENGTH_BITS'(1);
               if (left_in == '0) begin
                  do_finish = 1'b1;
                  fin_valid = 1'b1;
               end else begin
                  push              = 1'b1;
                  res.payload_valid = 1'b1;
                  res.payload_byte  = d;
               end
            end
            default: begin
               // first header byte
               hfirst_in = b;
               short_in  = 7'd0;
               hcount_in = 4'd0;
               key_in    = 32'd0;
               mphase_in = 2'd0;
               left_in   = '0;
               reason_in = 16'd0;
               if (strict_ff && (b[6:4] != 3'd0)) begin
                  do_fail = 1'b1;
               end else if ((b[3:0] > OP_BINARY && b[3:0] < OP_CLOSE) || b[3:0] > OP_PONG) begin
                  do_fail = 1'b1;
               end else begin
                  phase_in = PH_HDR1;
               end
            end
         endcase

         // header rules once the length is known
         if (do_known) begin
            if (op[3]) begin
               if (strict_ff && (left_in > LENGTH_BITS'(CTRL_MAX_LEN))) begin
                  do_fail = 1'b1;
               end else if (!hfirst_ff[7]) begin
                  do_fail = 1'b1;
               end else if ((op == OP_CLOSE) && (left_in == LENGTH_BITS'(1))) begin
                  do_fail = 1'b1;
               end
            end else if ((op == OP_CONT) && (msgop_ff == 2'd0)) begin
               do_fail = 1'b1;
            end else if ((op != OP_CONT) && (msgop_ff != 2'd0)) begin
               do_fail = 1'b1;
            end
            if (!do_fail) begin
               hcount_in = 4'd0;
               if (known_masked) begin
                  phase_in = PH_MASK;
               end else if (left_in == '0) begin
                  do_finish = 1'b1;
               end else begin
                  phase_in = PH_DATA;
               end
            end
         end

         if (do_fail) begin
            push          = 1'b1;
            res.frame_end = 1'b1;
            res.action    = fail_code;
            closed_in     = 1'b1;
         end

         if (do_finish) begin
            if (op == OP_CLOSE) begin
               fin_act   = ((hcount_in >= REASON_BYTES) && close_reason_bad(reason_in)) ?
                           ACT_CLOSE_ERR : ACT_CLOSE_OK;
               closed_in = 1'b1;
            end else if (op == OP_PING) begin
               fin_act = ACT_PONG;
            end else if (op == OP_PONG) begin
               fin_act = ACT_PONG_IGN;
            end else if (hfirst_ff[7]) begin
               fin_act  = ACT_COMPLETE;
               msgop_in = 2'd0;
            end else begin
               fin_act = ACT_FRAGMENT;
               if (op != OP_CONT) begin
                  msgop_in = op[1:0];
               end
            end
            push              = 1'b1;
            res.payload_valid = fin_valid;
            res.payload_byte  = fin_valid ? d : 8'd0;
            res.frame_end     = 1'b1;
            res.action        = fin_act;
            phase_in          = PH_HDR0;
         end

         res.message_type = (hfirst_in[3:0] != OP_CONT) ? hfirst_in[3:0] : {2'b00, msgop_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strict_ff <= STRICT_RESET;
         phase_ff  <= PH_HDR0;
         hfirst_ff <= 8'd0;
         short_ff  <= 7'd0;
         hcount_ff <= 4'd0;
         key_ff    <= 32'd0;
         mphase_ff <= 2'd0;
         left_ff   <= '0;
         msgop_ff  <= 2'd0;
         reason_ff <= 16'd0;
         closed_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            strict_ff <= csr_wr_data;
         end
         phase_ff  <= phase_in;
         hfirst_ff <= hfirst_in;
         short_ff  <= short_in;
         hcount_ff <= hcount_in;
         key_ff    <= key_in;
         mphase_ff <= mphase_in;
         left_ff   <= left_in;
         msgop_ff  <= msgop_in;
         reason_ff <= reason_in;
         closed_ff <= closed_in;
      end
   end

   // two-entry result buffer, so a waiting result does not stall the request side
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (pop) begin
            head_ff <= ~head_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[head_ff ^ count_ff[0]] <= res;
      end
   end

   assign req_tready = (count_ff != 2'd2);
   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tdata  = {5'd0, buf_ff[head_ff].action, buf_ff[head_ff].payload_byte};
   assign rsp_tuser  = {buf_ff[head_ff].message_type, buf_ff[head_ff].payload_valid};
   assign rsp_tlast  = buf_ff[head_ff].frame_end;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result buffer count out of range");

   a_no_result_after_close: assert property (@(posedge clock) disable iff (reset)
      closed_ff |-> !push)
      else $error("result produced after stream closed");

   a_error_closes: assert property (@(posedge clock) disable iff (reset)
      (push && (res.action == ACT_CLOSE_ERR || res.action == ACT_TOO_BIG)) |=> closed_ff)
      else $error("error verdict did not close the stream");

   a_byte_zero_when_invalid: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata[7:0] == 8'd0))
      else $error("payload byte nonzero without payload_valid");

endmodule
`default_nettype wire
